// ===== sv/dved_pkg.sv =====
package dved_pkg;

  localparam int unsigned POS_W      = 21;
  localparam int unsigned TICK_W     = 64;
  localparam int unsigned LIMIT_W    = 24;
  localparam int unsigned IDX_W      = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned OUT_DATA_W = 96;

  localparam logic [POS_W-1:0] SECTION_BYTES = 21'd1048576;
  localparam logic [IDX_W-1:0] LAST_IDX      = 4'd9;

  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TICK_COUNT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EVENT_LIMIT  = 2'd2;

  typedef enum logic [2:0] {
    ERR_NONE        = 3'd0,
    ERR_TRUNCATED   = 3'd1,
    ERR_BAD_VARINT  = 3'd2,
    ERR_TICK_OVF    = 3'd3,
    ERR_TICK_OUTSIDE = 3'd4,
    ERR_BAD_BUTTON  = 3'd5,
    ERR_TOO_MANY    = 3'd6
  } err_code_e;

  typedef struct packed {
    logic               channel_mode;
    logic [TICK_W-1:0]  tick_count;
    logic [LIMIT_W-1:0] event_limit;
  } dved_cfg_t;

  typedef struct packed {
    logic [TICK_W-1:0]  accum;
    logic [IDX_W-1:0]   byte_idx;
    logic [TICK_W-1:0]  prior_tick;
    logic [LIMIT_W-1:0] events_seen;
    logic [POS_W-1:0]   byte_pos;
    logic [POS_W-1:0]   varint_start;
    logic               err_latched;
    err_code_e          err_code;
    logic [POS_W-1:0]   err_offset;
  } dved_state_t;

  typedef struct packed {
    logic              event_valid;
    logic [TICK_W-1:0] tick;
    logic [1:0]        button;
    logic              player;
    logic              pressed;
    err_code_e         error_code;
    logic [POS_W-1:0]  error_offset;
    logic              section_end;
  } dved_result_t;

endpackage

// ===== sv/dved_step.sv =====
module dved_step import dved_pkg::*; (
  input  dved_cfg_t    cfg_i,
  input  dved_state_t  state_i,
  input  logic [7:0]   byte_i,
  input  logic         last_i,
  output dved_state_t  state_o,
  output logic         emit_o,
  output dved_result_t result_o
);

  logic [POS_W-1:0]  pos_nx;
  logic              first;
  logic [POS_W-1:0]  start;
  logic [IDX_W-1:0]  idx;
  logic [6:0]        shamt;
  logic [TICK_W-1:0] acc_new;
  logic              cont;
  logic [3:0]        st4;
  logic [TICK_W-1:0] delta;
  logic [TICK_W:0]   sum;
  logic [TICK_W-1:0] t;
  logic              is_event;
  err_code_e         code;
  logic [POS_W-1:0]  ofs;

  always_comb begin
    pos_nx = (state_i.byte_pos >= SECTION_BYTES) ? SECTION_BYTES
                                                 : state_i.byte_pos + 21'd1;
    first  = (state_i.byte_idx == '0);
    start  = first ? state_i.byte_pos : state_i.varint_start;
    idx    = (state_i.byte_idx > LAST_IDX) ? LAST_IDX : state_i.byte_idx;
    shamt  = {3'b000, idx} * 7'd7;
    acc_new = (first ? '0 : state_i.accum) | (TICK_W'(byte_i[6:0]) << shamt);
    cont   = byte_i[7];
    st4    = acc_new[3:0];
    delta  = cfg_i.channel_mode ? {4'b0000, acc_new[TICK_W-1:4]}
                                : {1'b0, acc_new[TICK_W-1:1]};
    sum    = {1'b0, state_i.prior_tick} + {1'b0, delta};
    t      = sum[TICK_W-1:0];
  end

  // Classify the byte; order of the checks decides which error wins.
  always_comb begin
    code     = ERR_NONE;
    ofs      = '0;
    is_event = 1'b0;
    if (!state_i.err_latched) begin
      priority if (first && (state_i.events_seen >= cfg_i.event_limit)) begin
        code = ERR_TOO_MANY;
        ofs  = state_i.byte_pos;
      end else if ((idx == LAST_IDX) && (byte_i[7:1] != '0)) begin
        code = ERR_BAD_VARINT;
        ofs  = start;
      end else if (cont) begin
        if (last_i) begin
          code = ERR_TRUNCATED;
          ofs  = pos_nx;
        end
      end else if ((idx != '0) && (byte_i == '0)) begin
        code = ERR_BAD_VARINT;
        ofs  = start;
      end else if (sum[TICK_W]) begin
        code = ERR_TICK_OVF;
        ofs  = start;
      end else if (t >= cfg_i.tick_count) begin
        code = ERR_TICK_OUTSIDE;
        ofs  = start;
      end else if (cfg_i.channel_mode && (st4[3:2] == 2'b11)) begin
        code = ERR_BAD_BUTTON;
        ofs  = start;
      end else begin
        is_event = 1'b1;
      end
    end
  end

  always_comb begin
    state_o = state_i;
    state_o.byte_pos = pos_nx;
    if (!state_i.err_latched) begin
      state_o.varint_start = start;
      state_o.accum        = acc_new;
      state_o.byte_idx     = cont ? idx + 4'd1 : '0;
      if (is_event) begin
        state_o.prior_tick  = t;
        state_o.events_seen = state_i.events_seen + 24'd1;
      end
      if (code != ERR_NONE) begin
        state_o.err_latched = 1'b1;
        state_o.err_code    = code;
        state_o.err_offset  = ofs;
      end
    end
    // Section over: start the next one from a clean slate.
    if (last_i) begin
      state_o = '{err_code: ERR_NONE, default: '0};
    end
  end

  always_comb begin
    result_o = '{error_code: ERR_NONE, default: '0};
    result_o.section_end = last_i;
    if (is_event) begin
      result_o.event_valid = 1'b1;
      result_o.tick        = t;
      result_o.button      = cfg_i.channel_mode ? st4[3:2] : 2'b00;
      result_o.player      = cfg_i.channel_mode & st4[1];
      result_o.pressed     = st4[0];
    end
    if (code != ERR_NONE) begin
      result_o.error_code   = code;
      result_o.error_offset = ofs;
    end else if (state_i.err_latched && last_i) begin
      result_o.error_code   = state_i.err_code;
      result_o.error_offset = state_i.err_offset;
    end
    emit_o = is_event || (code != ERR_NONE) || last_i;
  end

endmodule

// ===== sv/delta_varint_event_stream_decoder_core.sv =====
// Event-section decoder: bytes of a section enter on the s_axis channel, one
// transfer per byte, with s_axis_tlast on the section's last byte. Bytes are
// gathered into LEB128 varints; each varint is a tick delta plus status bits.
// A result leaves on the m_axis channel for each finished event, for the
// first error of a section, and always for the section's last byte (tlast).
// After an error the block swallows bytes until the section's last byte,
// which repeats the error code and offset.
// Configure through cfg_we_i/cfg_index_i/cfg_data_i while no byte is in
// flight: 0 channel mode, 1 tick count, 2 event limit.
// A byte accepted into the input register is decoded from there, and its result
// is registered into the output register before it is presented on m_axis.
// Throughput: one byte per cycle while no waiting result stalls it; the 64-bit
// tick add and bound compare in the decode step are combinational.
// Reset clears the section state and loads channel mode 0, tick count 0 and
// event limit 0xFFFFFF. When the receiver stalls the result is held; bytes
// that make no result keep flowing, a byte that makes one waits.
module delta_varint_event_stream_decoder_core import dved_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // [7:0] byte_value
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [63:0] tick, [65:64] button, [66] player, [67] pressed,
  // [70:68] error_code, [91:71] error_offset, [95:92] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tuser,   // [0] event_valid
  output logic                  m_axis_tlast
);

  dved_cfg_t    cfg_q;
  dved_state_t  state_q, state_d;
  dved_result_t res, out_q;
  logic         in_vld_q, out_vld_q;
  logic [7:0]   in_byte_q;
  logic         in_last_q;
  logic         emit, advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.channel_mode <= 1'b0;
      cfg_q.tick_count   <= '0;
      cfg_q.event_limit  <= '1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_CHANNEL_MODE: cfg_q.channel_mode <= cfg_data_i[0];
        REG_TICK_COUNT:   cfg_q.tick_count   <= cfg_data_i;
        REG_EVENT_LIMIT:  cfg_q.event_limit  <= cfg_data_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  dved_step u_step (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .byte_i   (in_byte_q),
    .last_i   (in_last_q),
    .state_o  (state_d),
    .emit_o   (emit),
    .result_o (res)
  );

  // Advance the held byte unless its result would overwrite one still waiting.
  assign advance       = in_vld_q && (!emit || !out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= '{err_code: ERR_NONE, default: '0};
    end else begin
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (advance) begin
        state_q <= state_d;
      end
      if (advance && emit) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
    if (advance && emit) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_q.event_valid;
  assign m_axis_tlast  = out_q.section_end;
  assign m_axis_tdata  = {4'b0000, out_q.error_offset, out_q.error_code, out_q.pressed,
                          out_q.player, out_q.button, out_q.tick};

  a_section_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_last_q |=> state_q.byte_pos == '0 && !state_q.err_latched)
    else $error("section state not cleared after last byte");

  a_event_or_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !(out_q.event_valid && out_q.error_code != ERR_NONE))
    else $error("result carries both an event and an error");

  a_offset_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.error_code == ERR_NONE |-> out_q.error_offset == '0)
    else $error("error offset set without an error");

  a_pos_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.byte_pos <= SECTION_BYTES)
    else $error("byte position past section size");

endmodule

// ===== dv/dved_event_checker.sv =====
`timescale 1ns / 100ps

// Watches both stream channels and the register port, decodes every accepted
// byte with its own copy of the section state, and compares each result
// transfer against the oldest outstanding prediction.
module dved_event_checker import dved_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // [7:0] byte_value
  input  logic                  s_axis_tlast,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [63:0] tick, [65:64] button, [66] player, [67] pressed,
  // [70:68] error_code, [91:71] error_offset, [95:92] zero
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  m_axis_tuser,   // [0] event_valid
  input  logic                  m_axis_tlast,
  output int                    fail_count_o,
  output int                    pending_o
);

  localparam int PRINT_MAX = 30;

  logic               cfg_chan;
  logic [TICK_W-1:0]  cfg_ticks;
  logic [LIMIT_W-1:0] cfg_limit;

  logic [TICK_W-1:0]  acc;
  logic [IDX_W-1:0]   vidx;
  logic [TICK_W-1:0]  last_tick;
  logic [LIMIT_W-1:0] n_events;
  logic [POS_W-1:0]   pos;
  logic [POS_W-1:0]   vstart;
  logic               err_hold;
  err_code_e          held_code;
  logic [POS_W-1:0]   held_ofs;

  dved_result_t due_results_q[$];
  int           results_seen;

  task automatic report_mismatch(input string msg);
    fail_count_o++;
    if (fail_count_o <= PRINT_MAX) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got 0x%0h, want 0x%0h",
                                results_seen, name, got, want));
  endtask

  function automatic logic [POS_W-1:0] step_pos(input logic [POS_W-1:0] p);
    return (p >= SECTION_BYTES) ? SECTION_BYTES : p + 1'b1;
  endfunction

  task automatic clear_section();
    acc       = '0;
    vidx      = '0;
    last_tick = '0;
    n_events  = '0;
    pos       = '0;
    vstart    = '0;
    err_hold  = 1'b0;
    held_code = ERR_NONE;
    held_ofs  = '0;
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic last);
    dved_result_t      r;
    err_code_e         code;
    logic [POS_W-1:0]  ofs;
    logic              emit;
    logic [IDX_W-1:0]  idx;
    int                shamt;
    logic [TICK_W-1:0] v;
    logic [TICK_W-1:0] delta;
    logic [TICK_W-1:0] t;
    logic [3:0]        st;
    r    = '0;
    code = ERR_NONE;
    ofs  = '0;
    emit = 1'b0;
    if (!err_hold) begin
      if (vidx == 0) begin
        vstart = pos;
        acc    = '0;
        if (n_events >= cfg_limit) begin
          code = ERR_TOO_MANY;
          ofs  = pos;
        end
      end
      if (code == ERR_NONE) begin
        idx = (vidx > LAST_IDX) ? LAST_IDX : vidx;
        if (idx == LAST_IDX && b[7:1] != 7'd0) begin
          // tenth byte may only carry bit 63
          code = ERR_BAD_VARINT;
          ofs  = vstart;
        end else begin
          shamt = idx * 7;
          acc   = acc | ({57'd0, b[6:0]} << shamt);
          if (!b[7]) begin
            vidx = '0;
            if (idx != 0 && b == 8'h00) begin
              code = ERR_BAD_VARINT;
              ofs  = vstart;
            end else begin
              v     = acc;
              st    = cfg_chan ? v[3:0] : {3'b000, v[0]};
              delta = cfg_chan ? (v >> 4) : (v >> 1);
              if (delta > ~last_tick) begin
                code = ERR_TICK_OVF;
                ofs  = vstart;
              end else begin
                t = last_tick + delta;
                if (t >= cfg_ticks) begin
                  code = ERR_TICK_OUTSIDE;
                  ofs  = vstart;
                end else if (cfg_chan && st[3:2] == 2'd3) begin
                  code = ERR_BAD_BUTTON;
                  ofs  = vstart;
                end else begin
                  r.event_valid = 1'b1;
                  r.tick        = t;
                  r.button      = cfg_chan ? st[3:2] : 2'd0;
                  r.player      = cfg_chan ? st[1] : 1'b0;
                  r.pressed     = st[0];
                  last_tick     = t;
                  n_events      = n_events + 1'b1;
                  emit          = 1'b1;
                end
              end
            end
          end else begin
            vidx = idx + 1'b1;
            if (last) begin
              code = ERR_TRUNCATED;
              ofs  = step_pos(pos);
            end
          end
        end
      end
      if (code != ERR_NONE) begin
        err_hold       = 1'b1;
        held_code      = code;
        held_ofs       = ofs;
        r.error_code   = code;
        r.error_offset = ofs;
        emit           = 1'b1;
      end
    end else if (last) begin
      // repeat the sticky error on the closing byte
      r.error_code   = held_code;
      r.error_offset = held_ofs;
      emit           = 1'b1;
    end
    pos = step_pos(pos);
    if (last) begin
      r.section_end = 1'b1;
      emit          = 1'b1;
      clear_section();
    end
    if (emit) due_results_q = {due_results_q, r};
  endtask

  always @(posedge clk_i) begin : monitor
    dved_result_t got;
    dved_result_t want;
    if (!rst_ni) begin
      cfg_chan  = 1'b0;
      cfg_ticks = '0;
      cfg_limit = '1;
      clear_section();
      due_results_q.delete();
    end else begin
      // compare first: a byte accepted at this edge cannot have a result yet
      if (m_axis_tvalid && m_axis_tready) begin
        got.event_valid  = m_axis_tuser;
        got.tick         = m_axis_tdata[63:0];
        got.button       = m_axis_tdata[65:64];
        got.player       = m_axis_tdata[66];
        got.pressed      = m_axis_tdata[67];
        got.error_code   = err_code_e'(m_axis_tdata[70:68]);
        got.error_offset = m_axis_tdata[91:71];
        got.section_end  = m_axis_tlast;
        if (due_results_q.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing outstanding",
                                    results_seen));
        end else begin
          want = due_results_q.pop_front();
          check_field("event_valid", got.event_valid, want.event_valid);
          check_field("tick", got.tick, want.tick);
          check_field("button", got.button, want.button);
          check_field("player", got.player, want.player);
          check_field("pressed", got.pressed, want.pressed);
          check_field("error_code", got.error_code, want.error_code);
          check_field("error_offset", got.error_offset, want.error_offset);
          check_field("section_end", got.section_end, want.section_end);
        end
        results_seen++;
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_CHANNEL_MODE: cfg_chan  = cfg_data_i[0];
          REG_TICK_COUNT:   cfg_ticks = cfg_data_i;
          REG_EVENT_LIMIT:  cfg_limit = cfg_data_i[LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) decode_byte(s_axis_tdata, s_axis_tlast);
    end
    pending_o = due_results_q.size();
  end

endmodule

// ===== dv/delta_varint_event_stream_decoder_core_test.sv =====
`timescale 1ns / 100ps

module delta_varint_event_stream_decoder_core_test;
  import dved_pkg::*;

  localparam int          HOLD_CYCLES  = 200;
  localparam int          RANDOM_BYTES = 1330;
  localparam logic [63:0] TICK_MAX     = 64'hFFFF_FFFF_FFFF_FFFF;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata  = '0;
  logic                  s_axis_tlast  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  m_axis_tlast;

  int   fail_count;
  int   pending;
  logic tx_idle_en  = 1'b1;
  logic rx_idle_en  = 1'b1;
  int   hold_req_cnt = 0;
  int   tx_count     = 0;
  logic cur_chan     = 1'b0;
  logic [7:0] sec_q[$];

  delta_varint_event_stream_decoder_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  dved_event_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // receiver: random back-pressure, plus a long hold-off on request
  initial begin : rx_side
    int hold_left = 0;
    int hold_seen = 0;
    forever begin
      @(negedge clk_i);
      if (hold_seen != hold_req_cnt) begin
        hold_seen = hold_req_cnt;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= !rx_idle_en || ($urandom_range(0, 99) >= 15);
      end
    end
  end

  initial begin : watchdog
    #500_000;
    $display("delta_varint_event_stream_decoder_core_test: FAIL");
    $finish;
  end

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic apply_config(input logic chan, input logic [63:0] ticks,
                              input logic [LIMIT_W-1:0] limit);
    cfg_write(REG_CHANNEL_MODE, {63'd0, chan});
    cfg_write(REG_TICK_COUNT, ticks);
    cfg_write(REG_EVENT_LIMIT, {40'd0, limit});
    cur_chan = chan;
  endtask

  // hold the sender until every predicted result has been taken
  task automatic wait_drained();
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    @(negedge clk_i);
    while (tx_idle_en && $urandom_range(0, 99) < 15) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    tx_count++;
  endtask

  task automatic send_section();
    foreach (sec_q[i]) send_byte(sec_q[i], i == sec_q.size() - 1);
    sec_q.delete();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic put_varint(input logic [63:0] v);
    logic [7:0] b;
    do begin
      b = {1'b0, v[6:0]};
      v = v >> 7;
      if (v != 0) b[7] = 1'b1;
      sec_q = {sec_q, b};
    end while (v != 0);
  endtask

  function automatic logic [63:0] pack_event(input logic [63:0] delta, input logic [3:0] st);
    return cur_chan ? {delta[59:0], st} : {delta[62:0], st[0]};
  endfunction

  function automatic logic [63:0] rand_delta();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 64'($urandom_range(0, 300));
    if (r < 90) return 64'($urandom_range(0, 1 << 20));
    if (r < 97) return {$urandom, $urandom} >> $urandom_range(0, 40);
    return {$urandom, $urandom};
  endfunction

  function automatic logic [3:0] rand_status();
    logic [1:0] btn;
    btn = ($urandom_range(0, 99) < 5) ? 2'd3 : 2'($urandom_range(0, 2));
    return {btn, 1'($urandom), 1'($urandom)};
  endfunction

  // well-formed events, rare bad varints, huge deltas or junk; truncation is last
  task automatic build_random_section();
    int n;
    int bad_at;
    int kind;
    n      = $urandom_range(1, 12);
    bad_at = ($urandom_range(0, 99) < 20) ? $urandom_range(0, n - 1) : -1;
    if ($urandom_range(0, 99) < 8) begin
      repeat ($urandom_range(1, 12)) sec_q = {sec_q, 8'($urandom)};
      return;
    end
    for (int i = 0; i < n; i++) begin
      if (i == bad_at) begin
        kind = $urandom_range(0, 4);
        case (kind)
          0: begin
            // non-canonical: padded with a zero final byte
            put_varint(pack_event(rand_delta(), rand_status()));
            sec_q[sec_q.size() - 1] = sec_q[sec_q.size() - 1] | 8'h80;
            repeat ($urandom_range(0, 2)) sec_q = {sec_q, 8'h80};
            sec_q = {sec_q, 8'h00};
          end
          1: begin
            // overlong: tenth byte above one
            repeat (9) sec_q = {sec_q, 8'h80 | 8'($urandom_range(0, 127))};
            sec_q = {sec_q, 8'($urandom_range(2, 255))};
          end
          2: begin
            repeat ($urandom_range(1, 3)) sec_q = {sec_q, 8'h80 | 8'($urandom)};
            return;
          end
          3: put_varint({1'b1, $urandom, 31'($urandom)});
          default: begin
            // three deltas of at least 2^62 in pressed-only mode; their sum may overflow
            repeat (3) put_varint({1'b1, $urandom, 31'($urandom)});
          end
        endcase
      end else begin
        put_varint(pack_event(rand_delta(), rand_status()));
      end
    end
  endtask

  initial begin : stimulus
    int         phase;
    int         stop_at;
    logic [63:0] ticks;
    logic [LIMIT_W-1:0] limit;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: field extremes and every error kind except tick overflow
    apply_config(1'b0, TICK_MAX, '1);
    sec_q = {sec_q, 8'h03};
    sec_q = {sec_q, 8'h81};
    sec_q = {sec_q, 8'h00};
    sec_q = {sec_q, 8'h00};
    send_section();
    repeat (9) sec_q = {sec_q, 8'hFF};
    sec_q = {sec_q, 8'h01};
    sec_q = {sec_q, 8'h80};
    send_section();
    wait_drained();

    apply_config(1'b1, 64'h100, 24'd1);
    sec_q = {sec_q, 8'h0C};
    sec_q = {sec_q, 8'h00};
    send_section();
    sec_q = {sec_q, 8'h16};
    sec_q = {sec_q, 8'h20};
    sec_q = {sec_q, 8'h00};
    send_section();
    sec_q = {sec_q, 8'h80};
    sec_q = {sec_q, 8'h20};
    sec_q = {sec_q, 8'h00};
    send_section();
    wait_drained();

    apply_config(1'b1, 64'd0, '1);
    sec_q = {sec_q, 8'h00};
    send_section();
    wait_drained();
    apply_config(1'b0, TICK_MAX, 24'd0);
    sec_q = {sec_q, 8'h00};
    send_section();
    wait_drained();

    // receiver holds off while a dense run of events keeps coming
    apply_config(1'b0, TICK_MAX, '1);
    hold_req_cnt++;
    repeat (40) put_varint(64'($urandom_range(0, 11)));
    send_section();
    wait_drained();

    stop_at = tx_count + RANDOM_BYTES;
    phase   = 0;
    while (tx_count < stop_at) begin
      case ($urandom_range(0, 3))
        0: ticks = TICK_MAX;
        1: ticks = 64'($urandom_range(1000, 100000));
        2: ticks = {$urandom, $urandom};
        default: ticks = 64'd1 << 40;
      endcase
      case ($urandom_range(0, 2))
        0: limit = '1;
        1: limit = 24'($urandom_range(1, 20));
        default: limit = 24'($urandom_range(0, 3));
      endcase
      apply_config(1'($urandom), ticks, limit);
      tx_idle_en = (phase != 3);
      rx_idle_en = (phase != 3);
      repeat ($urandom_range(4, 8)) begin
        build_random_section();
        send_section();
      end
      wait_drained();
      phase++;
    end

    if (fail_count == 0 && pending == 0) begin
      $display("delta_varint_event_stream_decoder_core_test: PASS");
    end else begin
      $display("delta_varint_event_stream_decoder_core_test: FAIL");
    end
    $finish;
  end

endmodule
